@@ design/tbss_pkg.sv @@
package tbss_pkg;

    // fixed field widths
    localparam int WORD_W          = 32;
    localparam int ROW_BLOCKS_W    = 8;
    localparam int STRIP_COUNT_W   = 7;
    localparam int CFG_DATA_W      = 8;
    localparam int CFG_INDEX_W     = 2;

    // tile geometry: 16-byte by 8-row blocks of 32-bit words
    localparam int ROW_WORDS       = 4;
    localparam int BLOCK_ROWS      = 8;
    localparam int BLOCK_WORDS     = ROW_WORDS * BLOCK_ROWS;

    // default strip width limit in blocks
    localparam int MAX_ROW_BLOCKS_DEF = 128;

    // depth of the result queue in the back
    localparam int QDEPTH          = 4;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_BLOCKS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIP_COUNT = 2'd2;

    // item kinds
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // direction codes
    localparam logic DIR_SWIZZLE   = 1'b0;
    localparam logic DIR_UNSWIZZLE = 1'b1;

    // read request from front to back
    typedef struct packed {
        logic valid;
        logic last;
    } tbss_issue_t;

    // back status seen by front
    typedef struct packed {
        logic room;
    } tbss_status_t;

endpackage

@@ design/tbss_ifs.sv @@
interface tbss_item_if;
    import tbss_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [WORD_W-1:0] in_word;

    modport source (output valid, output kind, output in_word, input ready);
    modport sink   (input valid, input kind, input in_word, output ready);
endinterface

interface tbss_result_if;
    import tbss_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] out_word;
    logic              last_of_image;

    modport source (output valid, output out_word, output last_of_image, input ready);
    modport sink   (input valid, input out_word, input last_of_image, output ready);
endinterface

interface tbss_cfg_if;
    import tbss_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/tbss_ram.sv @@
module tbss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/tbss_front.sv @@
module tbss_front #(
    parameter int MAX_ROW_BLOCKS = tbss_pkg::MAX_ROW_BLOCKS_DEF,
    localparam int AW = $clog2(2 * MAX_ROW_BLOCKS * tbss_pkg::BLOCK_WORDS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    tbss_item_if.sink                   item,
    tbss_cfg_if.sink                    cfg,
    input  tbss_pkg::tbss_status_t      status,
    output tbss_pkg::tbss_issue_t       issue,
    output logic                        ram_we,
    output logic [AW-1:0]               ram_waddr,
    output logic [tbss_pkg::WORD_W-1:0] ram_wdata,
    output logic                        ram_re,
    output logic [AW-1:0]               ram_raddr
);
    import tbss_pkg::*;

    localparam int BANK_WORDS = MAX_ROW_BLOCKS * BLOCK_WORDS;
    localparam int PW      = $clog2(BANK_WORDS);
    localparam int SW      = $clog2(BANK_WORDS + 1);
    localparam int BW      = $clog2(MAX_ROW_BLOCKS + 1);
    localparam int ROW_SH  = $clog2(ROW_WORDS);
    localparam int BLK_SH  = $clog2(BLOCK_WORDS);
    localparam int ROWS_SH = BLK_SH - ROW_SH;
    localparam int QW      = PW - ROW_SH;
    localparam int CNW     = $clog2(QW + 1);
    localparam int AFW     = PW + ROW_SH;

    // configuration registers
    logic                     direction_reg, direction_next;
    logic [ROW_BLOCKS_W-1:0]  row_blocks_reg, row_blocks_next;
    logic [STRIP_COUNT_W-1:0] strip_count_reg, strip_count_next;

    // stream state
    logic [PW-1:0]            wp_reg, wp_next;
    logic [PW-1:0]            rp_reg, rp_next;
    logic                     wb_reg, wb_next;
    logic                     pending_reg, pending_next;
    logic [STRIP_COUNT_W-1:0] written_reg, written_next;

    // read position split into row group (q) and block column (m)
    logic [QW-1:0]            q_reg, q_next;
    logic [BW-1:0]            m_reg, m_next;

    // divider that realigns q and m after a width change
    logic                     div_busy_reg, div_busy_next;
    logic [CNW-1:0]           div_cnt_reg, div_cnt_next;
    logic [QW-1:0]            div_num_reg, div_num_next;
    logic [BW-1:0]            div_rem_reg, div_rem_next;

    logic [BW-1:0]            rb_eff;
    logic [SW-1:0]            strip_words;
    logic                     cfg_wr;
    logic                     accept;
    logic                     image_written;
    logic                     data_take;
    logic                     data_emit;
    logic                     drain_emit;
    logic [SW-1:0]            wp_inc;
    logic [SW-1:0]            rp_inc;
    logic                     wp_done;
    logic                     rp_done;
    logic [PW-1:0]            adv_rp;
    logic [QW-1:0]            adv_q;
    logic [BW-1:0]            adv_m;
    logic [BW:0]              div_trial;
    logic                     div_ge;
    logic [BW-1:0]            div_rem_step;
    logic [QW-1:0]            div_num_step;
    logic [ROWS_SH-1:0]       w_row;
    logic [PW-1:0]            bx;
    logic [PW-1:0]            t_lin;
    logic [PW-1:0]            t_til;
    logic [PW-1:0]            t_sel;
    logic [AFW-1:0]           a_full;
    logic [AFW-1:0]           a_mod;

    // effective strip width, clamped to 1..MAX_ROW_BLOCKS
    always_comb
    begin
        if (row_blocks_reg == '0)
        begin
            rb_eff = BW'(1);
        end
        else if (int'(row_blocks_reg) > MAX_ROW_BLOCKS)
        begin
            rb_eff = BW'(MAX_ROW_BLOCKS);
        end
        else
        begin
            rb_eff = BW'(row_blocks_reg);
        end
    end

    assign strip_words = SW'(rb_eff) << BLK_SH;

    // handshakes and classification
    assign cfg.ready     = 1'b1;
    assign cfg_wr        = cfg.valid && cfg.ready;
    assign item.ready    = !div_busy_reg && status.room;
    assign accept        = item.valid && item.ready;
    assign image_written = written_reg >= strip_count_reg;
    assign data_take     = accept && (item.kind == KIND_DATA) && !image_written;
    assign data_emit     = data_take && pending_reg;
    assign drain_emit    = accept && (item.kind == KIND_DRAIN) && pending_reg && image_written;

    assign wp_inc  = SW'(wp_reg) + SW'(1);
    assign rp_inc  = SW'(rp_reg) + SW'(1);
    assign wp_done = wp_inc >= strip_words;
    assign rp_done = rp_inc >= strip_words;

    // read position step, keeping the row group and column in line
    always_comb
    begin
        adv_rp = PW'(rp_inc);
        adv_q  = q_reg;
        adv_m  = m_reg;
        if (rp_inc == SW'(BANK_WORDS))
        begin
            adv_rp = '0;
            adv_q  = '0;
            adv_m  = '0;
        end
        else if (&rp_reg[ROW_SH-1:0])
        begin
            if ((m_reg + BW'(1)) >= rb_eff)
            begin
                adv_m = '0;
                adv_q = q_reg + QW'(1);
            end
            else
            begin
                adv_m = m_reg + BW'(1);
            end
        end
    end

    // one restoring division step
    assign div_trial    = {div_rem_reg, div_num_reg[QW-1]};
    assign div_ge       = div_trial >= {1'b0, rb_eff};
    assign div_rem_step = div_ge ? BW'(div_trial - {1'b0, rb_eff}) : div_trial[BW-1:0];
    assign div_num_step = {div_num_reg[QW-2:0], div_ge};

    // next state
    always_comb
    begin
        direction_next   = direction_reg;
        row_blocks_next  = row_blocks_reg;
        strip_count_next = strip_count_reg;
        wp_next          = wp_reg;
        rp_next          = rp_reg;
        wb_next          = wb_reg;
        pending_next     = pending_reg;
        written_next     = written_reg;
        q_next           = q_reg;
        m_next           = m_reg;
        div_busy_next    = div_busy_reg;
        div_cnt_next     = div_cnt_reg;
        div_num_next     = div_num_reg;
        div_rem_next     = div_rem_reg;

        // data word into the write bank
        if (data_take)
        begin
            if (data_emit)
            begin
                rp_next = adv_rp;
                q_next  = adv_q;
                m_next  = adv_m;
            end
            if (wp_done)
            begin
                wp_next      = '0;
                rp_next      = '0;
                q_next       = '0;
                m_next       = '0;
                wb_next      = !wb_reg;
                pending_next = 1'b1;
                written_next = written_reg + STRIP_COUNT_W'(1);
            end
            else
            begin
                wp_next = (wp_inc == SW'(BANK_WORDS)) ? '0 : PW'(wp_inc);
            end
        end

        // drain of the final bank
        if (drain_emit)
        begin
            if (rp_done)
            begin
                rp_next      = '0;
                q_next       = '0;
                m_next       = '0;
                pending_next = 1'b0;
                written_next = '0;
            end
            else
            begin
                rp_next = adv_rp;
                q_next  = adv_q;
                m_next  = adv_m;
            end
        end

        // divider iteration
        if (div_busy_reg)
        begin
            div_num_next = div_num_step;
            div_rem_next = div_rem_step;
            div_cnt_next = div_cnt_reg - CNW'(1);
            if (div_cnt_reg == CNW'(1))
            begin
                div_busy_next = 1'b0;
                q_next        = div_num_step;
                m_next        = div_rem_step;
            end
        end

        // register writes
        if (cfg_wr)
        begin
            unique case (cfg.index)
                REG_DIRECTION:
                begin
                    direction_next = cfg.data[0];
                end
                REG_ROW_BLOCKS:
                begin
                    row_blocks_next = cfg.data[ROW_BLOCKS_W-1:0];
                    div_busy_next   = 1'b1;
                    div_cnt_next    = CNW'(QW);
                    div_num_next    = rp_reg[PW-1:ROW_SH];
                    div_rem_next    = '0;
                end
                REG_STRIP_COUNT:
                begin
                    strip_count_next = cfg.data[STRIP_COUNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= DIR_SWIZZLE;
            row_blocks_reg  <= ROW_BLOCKS_W'(1);
            strip_count_reg <= STRIP_COUNT_W'(1);
            wp_reg          <= '0;
            rp_reg          <= '0;
            wb_reg          <= 1'b0;
            pending_reg     <= 1'b0;
            written_reg     <= '0;
            q_reg           <= '0;
            m_reg           <= '0;
            div_busy_reg    <= 1'b0;
            div_cnt_reg     <= '0;
        end
        else
        begin
            direction_reg   <= direction_next;
            row_blocks_reg  <= row_blocks_next;
            strip_count_reg <= strip_count_next;
            wp_reg          <= wp_next;
            rp_reg          <= rp_next;
            wb_reg          <= wb_next;
            pending_reg     <= pending_next;
            written_reg     <= written_next;
            q_reg           <= q_next;
            m_reg           <= m_next;
            div_busy_reg    <= div_busy_next;
            div_cnt_reg     <= div_cnt_next;
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        div_num_reg <= div_num_next;
        div_rem_reg <= div_rem_next;
    end

    // offset of the next output word in the pending bank
    assign w_row = rp_reg[BLK_SH-1:ROW_SH];
    assign bx    = rp_reg >> BLK_SH;
    assign t_lin = PW'(w_row) * PW'(rb_eff) + bx;
    assign t_til = (PW'(m_reg) << ROWS_SH) + PW'(q_reg);
    assign t_sel = (direction_reg == DIR_UNSWIZZLE) ? t_til : t_lin;
    assign a_full = {t_sel, rp_reg[ROW_SH-1:0]};
    assign a_mod  = (a_full >= AFW'(BANK_WORDS)) ? a_full - AFW'(BANK_WORDS) : a_full;

    // memory ports: write bank and the other (pending) bank
    assign ram_we    = data_take;
    assign ram_waddr = (wb_reg ? AW'(BANK_WORDS) : AW'(0)) + AW'(wp_reg);
    assign ram_wdata = item.in_word;
    assign ram_re    = data_emit || drain_emit;
    assign ram_raddr = (wb_reg ? AW'(0) : AW'(BANK_WORDS)) + AW'(PW'(a_mod));

    // request to the back
    assign issue.valid = data_emit || drain_emit;
    assign issue.last  = drain_emit && rp_done;

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_reg |-> !item.ready)
        else $error("item accepted while read counters realign");

    a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid |-> pending_reg)
        else $error("read issued with no strip pending");

    a_last_ends_image: assert property (@(posedge clk) disable iff (!rst_n)
        (issue.valid && issue.last) |=> (!pending_reg && written_reg == '0))
        else $error("image state not cleared after final word");

    a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |->
            ((ram_waddr >= AW'(BANK_WORDS)) != (ram_raddr >= AW'(BANK_WORDS))))
        else $error("write and read hit the same bank");

endmodule

@@ design/tbss_back.sv @@
module tbss_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tbss_pkg::tbss_issue_t       issue,
    input  logic [tbss_pkg::WORD_W-1:0] ram_rdata,
    output tbss_pkg::tbss_status_t      status,
    tbss_result_if.source               result
);
    import tbss_pkg::*;

    localparam int QPW = $clog2(QDEPTH);
    localparam int CW  = $clog2(QDEPTH + 1);

    logic              pend_valid_reg;
    logic              pend_last_reg;
    logic [WORD_W-1:0] q_word_reg [QDEPTH];
    logic              q_last_reg [QDEPTH];
    logic [QPW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     used_reg, used_next;
    logic              push;
    logic              pop;

    // memory data lands in the cycle after the read request
    assign push = pend_valid_reg;
    assign pop  = result.valid && result.ready;

    // queue pointers, fill count and credit count (queue plus read in flight)
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
        used_next  = used_reg + CW'(issue.valid) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            used_reg       <= '0;
        end
        else
        begin
            pend_valid_reg <= issue.valid;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
            used_reg       <= used_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        pend_last_reg <= issue.last;
        if (push)
        begin
            q_word_reg[wr_ptr_reg] <= ram_rdata;
            q_last_reg[wr_ptr_reg] <= pend_last_reg;
        end
    end

    assign status.room          = used_reg < CW'(QDEPTH);
    assign result.valid         = count_reg != '0;
    assign result.out_word      = q_word_reg[rd_ptr_reg];
    assign result.last_of_image = q_last_reg[rd_ptr_reg];

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(QDEPTH))
        else $error("more requests outstanding than queue entries");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CW'(QDEPTH)))
        else $error("memory data arrived at a full queue");

    a_count_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg + CW'(pend_valid_reg)) <= used_reg)
        else $error("queue fill exceeds credit count");

endmodule

@@ design/texture_block_swizzle_stream.sv @@
// Texture strip reorder between linear rows and 16-byte by 8-row tiles. Items
// are accepted one per cycle when the input is not stalled; a data item writes
// its word into the current strip bank of the strip memory and, once a previous
// strip is pending, reads one word of it back, so write and read share no bank
// in any cycle. Drain items read out the final bank once the whole image is
// written. A result passes the registered memory read and then the four-entry
// result queue, which lets input continue while the output stalls until the
// queue and the read in flight fill it. After a write of row_blocks the input
// stalls while a shift-subtract divider realigns the read position with the new
// strip width. The strip memory needs no clearing pass.
module texture_block_swizzle_stream #(
    parameter int MAX_ROW_BLOCKS = tbss_pkg::MAX_ROW_BLOCKS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    tbss_item_if.sink     item,
    tbss_cfg_if.sink      cfg,
    tbss_result_if.source result
);
    import tbss_pkg::*;

    localparam int RAM_DEPTH = 2 * MAX_ROW_BLOCKS * BLOCK_WORDS;
    localparam int AW        = $clog2(RAM_DEPTH);

    tbss_issue_t       issue;
    tbss_status_t      status;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // accept, classify and address
    tbss_front #(
        .MAX_ROW_BLOCKS (MAX_ROW_BLOCKS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg),
        .status    (status),
        .issue     (issue),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    // two strip banks
    tbss_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_strip_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result queue and output
    tbss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .ram_rdata (ram_rdata),
        .status    (status),
        .result    (result)
    );

endmodule
